// ===== src/fmmp_pkg.sv =====
package fmmp_pkg;

    localparam int IDX_W = 64;
    localparam int MOD_W = 32;
    localparam logic [MOD_W-1:0] MOD_RESET = 32'd1000000007;

    typedef enum logic
    {
        OP_ADD,
        OP_MUL
    } op_t;

    // working registers of the datapath
    typedef enum logic [3:0]
    {
        R_A,
        R_B,
        R_D,
        R_P,
        R_Q,
        R_S,
        R_T0,
        R_T1,
        R_T2
    } reg_sel_t;

    typedef struct packed
    {
        op_t      op;
        reg_sel_t src_a;
        reg_sel_t src_b;
        reg_sel_t dst;
    } uop_t;

    typedef struct packed
    {
        logic init;
        logic issue;
        uop_t uop;
        logic load_out;
        logic zero_out;
    } dp_cmd_t;

    typedef struct packed
    {
        logic mul_done;
        logic recip_ready;
        logic mod_small;
    } dp_status_t;

endpackage

// ===== src/fibonacci_mod_matrix_power.sv =====
// fibonacci_mod_matrix_power: F(index) mod modulus by binary powering of [[0,1],[1,1]]
//
// input stream s_*: one beat carries a 64-bit index; output stream m_*: one beat
// carries the 32-bit result. every input beat gives exactly one output beat.
// cfg_we/cfg_wdata write the modulus (reset value 1000000007); write it only
// while no item is in flight.
//
// one item at a time. the index is scanned lsb first up to its highest set bit;
// each bit but the highest costs a squaring, plus a multiply into the accumulator
// when the bit is set; index zero goes straight to the output. the time per item is
// set by the single shared 32x32 multiplier, which forms each modular product by
// barrett reduction with a stored reciprocal.
//
// after reset, and after every modulus write, s_tready stays low while the
// reciprocal of the modulus is built one bit a cycle.
// the result sits in an output register: a new index is taken while it waits,
// and the next result waits in the datapath until m_tready frees the register.
module fibonacci_mod_matrix_power
#(
    parameter int INDEX_BITS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // [63:0] index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [31:0] fib_value
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata    // [31:0] modulus
);
    import fmmp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    fmmp_ctrl
    #(
        .INDEX_BITS (INDEX_BITS)
    )
    u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fmmp_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .fib_value (m_tdata)
    );

endmodule

// ===== src/fmmp_recip.sv =====
module fmmp_recip
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         restart,
    input  logic [fmmp_pkg::MOD_W-1:0]   divisor,
    output logic [2*fmmp_pkg::MOD_W-1:0] quotient,
    output logic                         ready
);
    import fmmp_pkg::*;

    localparam int STEPS = 2 * MOD_W;
    localparam int CNT_W = $clog2(STEPS);

    typedef enum logic [1:0]
    {
        RC_LOAD,
        RC_RUN,
        RC_READY
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [MOD_W-1:0]   rem_reg;
    logic [STEPS-1:0]   quo_reg;

    logic [MOD_W:0]     rem_sh;
    logic [MOD_W:0]     rem_diff;
    logic               rem_ge;

    // restoring division of 2^64 by the modulus, one quotient bit a cycle
    assign rem_sh   = {rem_reg, 1'b0};
    assign rem_diff = rem_sh - {1'b0, divisor};
    assign rem_ge   = rem_sh >= {1'b0, divisor};

    assign quotient = quo_reg;
    assign ready    = state_reg == RC_READY;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RC_LOAD;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
        end
        else if (restart)
        begin
            state_reg <= RC_LOAD;
        end
        else
        begin
            unique case (state_reg)
                RC_LOAD:
                begin
                    // leading one of 2^64 already brought down
                    rem_reg   <= MOD_W'(1);
                    cnt_reg   <= '0;
                    state_reg <= RC_RUN;
                end
                RC_RUN:
                begin
                    rem_reg <= rem_ge ? rem_diff[MOD_W-1:0] : rem_sh[MOD_W-1:0];
                    quo_reg <= {quo_reg[STEPS-2:0], rem_ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(STEPS - 1))
                    begin
                        state_reg <= RC_READY;
                    end
                end
                RC_READY:
                begin
                    state_reg <= RC_READY;
                end
                default:
                begin
                    state_reg <= RC_LOAD;
                end
            endcase
        end
    end

endmodule

// ===== src/fmmp_mulmod.sv =====
module fmmp_mulmod
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [fmmp_pkg::MOD_W-1:0]   a,
    input  logic [fmmp_pkg::MOD_W-1:0]   b,
    input  logic [fmmp_pkg::MOD_W-1:0]   modulus,
    input  logic [2*fmmp_pkg::MOD_W-1:0] recip,
    output logic                         done,
    output logic [fmmp_pkg::MOD_W-1:0]   result
);
    import fmmp_pkg::*;

    localparam int PW = 2 * MOD_W;
    localparam int TW = PW + 2;
    localparam int RW = MOD_W + 2;

    typedef enum logic [2:0]
    {
        MM_IDLE,
        MM_LL,
        MM_HL,
        MM_LH,
        MM_HH,
        MM_RED,
        MM_FIX
    } state_t;

    state_t            state_reg;
    logic [PW-1:0]     x_reg;
    logic [TW-1:0]     t_reg;
    logic [MOD_W-1:0]  q_reg;
    logic [RW-1:0]     r_reg;
    logic [MOD_W-1:0]  res_reg;
    logic              done_reg;

    logic [MOD_W-1:0]  mul_a;
    logic [MOD_W-1:0]  mul_b;
    logic [PW-1:0]     prod;
    logic [TW-1:0]     shift_sum;
    logic [TW-1:0]     lh_sum;
    logic [RW-1:0]     red_diff;
    logic [RW-1:0]     fix_diff;
    logic              fix_ge;

    // one shared 32x32 multiplier; barrett estimate q = hi64(x * floor(2^64/m))
    always_comb
    begin
        unique case (state_reg)
            MM_IDLE:
            begin
                mul_a = a;
                mul_b = b;
            end
            MM_LL:
            begin
                mul_a = x_reg[MOD_W-1:0];
                mul_b = recip[MOD_W-1:0];
            end
            MM_HL:
            begin
                mul_a = x_reg[PW-1:MOD_W];
                mul_b = recip[MOD_W-1:0];
            end
            MM_LH:
            begin
                mul_a = x_reg[MOD_W-1:0];
                mul_b = recip[PW-1:MOD_W];
            end
            MM_HH:
            begin
                mul_a = x_reg[PW-1:MOD_W];
                mul_b = recip[PW-1:MOD_W];
            end
            MM_RED:
            begin
                mul_a = q_reg;
                mul_b = modulus;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod      = {{MOD_W{1'b0}}, mul_a} * {{MOD_W{1'b0}}, mul_b};
    assign shift_sum = {{MOD_W{1'b0}}, t_reg[TW-1:MOD_W]} + {2'b00, prod};
    assign lh_sum    = t_reg + {2'b00, prod};
    // estimate is short by at most one, so the remainder is below 2m
    assign red_diff  = x_reg[RW-1:0] - prod[RW-1:0];
    assign fix_diff  = r_reg - {2'b00, modulus};
    assign fix_ge    = r_reg >= {2'b00, modulus};

    assign done   = done_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MM_IDLE;
            done_reg  <= 1'b0;
            x_reg     <= '0;
            t_reg     <= '0;
            q_reg     <= '0;
            r_reg     <= '0;
            res_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                MM_IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= prod;
                        state_reg <= MM_LL;
                    end
                end
                MM_LL:
                begin
                    t_reg     <= {2'b00, prod};
                    state_reg <= MM_HL;
                end
                MM_HL:
                begin
                    t_reg     <= shift_sum;
                    state_reg <= MM_LH;
                end
                MM_LH:
                begin
                    t_reg     <= lh_sum;
                    state_reg <= MM_HH;
                end
                MM_HH:
                begin
                    q_reg     <= shift_sum[MOD_W-1:0];
                    state_reg <= MM_RED;
                end
                MM_RED:
                begin
                    r_reg     <= red_diff;
                    state_reg <= MM_FIX;
                end
                MM_FIX:
                begin
                    res_reg   <= fix_ge ? fix_diff[MOD_W-1:0] : r_reg[MOD_W-1:0];
                    done_reg  <= 1'b1;
                    state_reg <= MM_IDLE;
                end
                default:
                begin
                    state_reg <= MM_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/fmmp_datapath.sv =====
module fmmp_datapath
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [fmmp_pkg::MOD_W-1:0] cfg_wdata,
    input  fmmp_pkg::dp_cmd_t          cmd,
    output fmmp_pkg::dp_status_t       status,
    output logic [fmmp_pkg::MOD_W-1:0] fib_value
);
    import fmmp_pkg::*;

    // accumulator [a b; b d] and power [p q; q s] stay symmetric
    logic [MOD_W-1:0]   a_reg;
    logic [MOD_W-1:0]   b_reg;
    logic [MOD_W-1:0]   d_reg;
    logic [MOD_W-1:0]   p_reg;
    logic [MOD_W-1:0]   q_reg;
    logic [MOD_W-1:0]   s_reg;
    logic [MOD_W-1:0]   t0_reg;
    logic [MOD_W-1:0]   t1_reg;
    logic [MOD_W-1:0]   t2_reg;
    logic [MOD_W-1:0]   modulus_reg;
    logic [MOD_W-1:0]   fib_reg;

    logic [MOD_W-1:0]   opa;
    logic [MOD_W-1:0]   opb;
    logic [MOD_W:0]     sum;
    logic [MOD_W:0]     sum_diff;
    logic [MOD_W-1:0]   add_res;
    logic               add_we;
    logic               mul_start;
    logic               mul_done;
    logic [MOD_W-1:0]   mul_res;
    logic               wr_en;
    logic [MOD_W-1:0]   wr_data;
    logic [2*MOD_W-1:0] recip;
    logic               recip_ready;

    always_comb
    begin
        unique case (cmd.uop.src_a)
            R_A:     opa = a_reg;
            R_B:     opa = b_reg;
            R_D:     opa = d_reg;
            R_P:     opa = p_reg;
            R_Q:     opa = q_reg;
            R_S:     opa = s_reg;
            R_T0:    opa = t0_reg;
            R_T1:    opa = t1_reg;
            R_T2:    opa = t2_reg;
            default: opa = '0;
        endcase
    end

    always_comb
    begin
        unique case (cmd.uop.src_b)
            R_A:     opb = a_reg;
            R_B:     opb = b_reg;
            R_D:     opb = d_reg;
            R_P:     opb = p_reg;
            R_Q:     opb = q_reg;
            R_S:     opb = s_reg;
            R_T0:    opb = t0_reg;
            R_T1:    opb = t1_reg;
            R_T2:    opb = t2_reg;
            default: opb = '0;
        endcase
    end

    // both operands are already reduced, one conditional subtract is enough
    assign sum      = {1'b0, opa} + {1'b0, opb};
    assign sum_diff = sum - {1'b0, modulus_reg};
    assign add_res  = (sum >= {1'b0, modulus_reg}) ? sum_diff[MOD_W-1:0] : sum[MOD_W-1:0];

    assign add_we    = cmd.issue && (cmd.uop.op == OP_ADD);
    assign mul_start = cmd.issue && (cmd.uop.op == OP_MUL);
    assign wr_en     = add_we || mul_done;
    assign wr_data   = add_we ? add_res : mul_res;

    fmmp_recip u_recip
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (cfg_we),
        .divisor  (modulus_reg),
        .quotient (recip),
        .ready    (recip_ready)
    );

    fmmp_mulmod u_mulmod
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (opa),
        .b       (opb),
        .modulus (modulus_reg),
        .recip   (recip),
        .done    (mul_done),
        .result  (mul_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_RESET;
        end
        else if (cfg_we)
        begin
            modulus_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            a_reg <= MOD_W'(1);
            b_reg <= '0;
            d_reg <= MOD_W'(1);
            p_reg <= '0;
            q_reg <= MOD_W'(1);
            s_reg <= MOD_W'(1);
        end
        else if (wr_en)
        begin
            unique case (cmd.uop.dst)
                R_A:     a_reg  <= wr_data;
                R_B:     b_reg  <= wr_data;
                R_D:     d_reg  <= wr_data;
                R_P:     p_reg  <= wr_data;
                R_Q:     q_reg  <= wr_data;
                R_S:     s_reg  <= wr_data;
                R_T0:    t0_reg <= wr_data;
                R_T1:    t1_reg <= wr_data;
                R_T2:    t2_reg <= wr_data;
                default: t0_reg <= t0_reg;
            endcase
        end
        if (cmd.load_out)
        begin
            fib_reg <= cmd.zero_out ? '0 : b_reg;
        end
    end

    assign fib_value          = fib_reg;
    assign status.mul_done    = mul_done;
    assign status.recip_ready = recip_ready;
    assign status.mod_small   = modulus_reg <= MOD_W'(1);

endmodule

// ===== src/fmmp_ctrl.sv =====
module fmmp_ctrl
#(
    parameter int INDEX_BITS = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [fmmp_pkg::IDX_W-1:0] s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    input  fmmp_pkg::dp_status_t       status,
    output fmmp_pkg::dp_cmd_t          cmd
);
    import fmmp_pkg::*;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_STEP,
        ST_RUN,
        ST_WAIT,
        ST_FINISH
    } state_t;

    localparam logic [3:0] PC_MUL_FIRST = 4'd0;
    localparam logic [3:0] PC_MUL_LAST  = 4'd7;
    localparam logic [3:0] PC_SQ_FIRST  = 4'd8;
    localparam logic [3:0] PC_SQ_LAST   = 4'd14;

    // acc *= pow, then pow *= pow, on the three distinct entries of each
    function automatic uop_t ucode(input logic [3:0] pc);
        uop_t u;
        begin
            unique case (pc)
                4'd0:    u = '{OP_MUL, R_A,  R_P,  R_T0};
                4'd1:    u = '{OP_MUL, R_B,  R_Q,  R_T1};
                4'd2:    u = '{OP_MUL, R_A,  R_Q,  R_T2};
                4'd3:    u = '{OP_ADD, R_T0, R_T1, R_A};
                4'd4:    u = '{OP_MUL, R_B,  R_S,  R_T0};
                4'd5:    u = '{OP_ADD, R_T2, R_T0, R_B};
                4'd6:    u = '{OP_MUL, R_D,  R_S,  R_T0};
                4'd7:    u = '{OP_ADD, R_T1, R_T0, R_D};
                4'd8:    u = '{OP_MUL, R_P,  R_P,  R_T0};
                4'd9:    u = '{OP_MUL, R_Q,  R_Q,  R_T1};
                4'd10:   u = '{OP_MUL, R_S,  R_S,  R_T2};
                4'd11:   u = '{OP_ADD, R_P,  R_S,  R_P};
                4'd12:   u = '{OP_MUL, R_Q,  R_P,  R_Q};
                4'd13:   u = '{OP_ADD, R_T0, R_T1, R_P};
                4'd14:   u = '{OP_ADD, R_T1, R_T2, R_S};
                default: u = '{OP_ADD, R_T0, R_T0, R_T0};
            endcase
            return u;
        end
    endfunction

    state_t                state_reg;
    state_t                state_next;
    logic [3:0]            pc_reg;
    logic [3:0]            pc_next;
    logic [INDEX_BITS-1:0] n_reg;
    logic [INDEX_BITS-1:0] n_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    uop_t                  uop;
    logic                  accept;
    logic                  out_free;
    logic                  uop_done;
    logic                  upper_zero;

    assign uop        = ucode(pc_reg);
    assign s_tready   = (state_reg == ST_IDLE) && status.recip_ready;
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign uop_done   = ((state_reg == ST_RUN) && (uop.op == OP_ADD))
                        || ((state_reg == ST_WAIT) && status.mul_done);
    assign upper_zero = (n_reg >> 1) == '0;
    assign m_tvalid   = out_valid_reg;

    assign cmd.init     = accept;
    assign cmd.issue    = state_reg == ST_RUN;
    assign cmd.uop      = uop;
    assign cmd.load_out = (state_reg == ST_FINISH) && out_free;
    assign cmd.zero_out = status.mod_small;

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    n_next = s_tdata[INDEX_BITS-1:0];
                    if (status.mod_small || (s_tdata[INDEX_BITS-1:0] == '0))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP:
            begin
                pc_next    = n_reg[0] ? PC_MUL_FIRST : PC_SQ_FIRST;
                state_next = ST_RUN;
            end
            ST_RUN, ST_WAIT:
            begin
                if (uop_done)
                begin
                    priority if (pc_reg == PC_MUL_LAST)
                    begin
                        // no set bit left: the last squaring is not needed
                        if (upper_zero)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            pc_next    = PC_SQ_FIRST;
                            state_next = ST_RUN;
                        end
                    end
                    else if (pc_reg == PC_SQ_LAST)
                    begin
                        n_next     = n_reg >> 1;
                        state_next = upper_zero ? ST_FINISH : ST_STEP;
                    end
                    else
                    begin
                        pc_next    = pc_reg + 1'b1;
                        state_next = ST_RUN;
                    end
                end
                else if (state_reg == ST_RUN)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/fmmp_checker.sv =====
module fmmp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        cfg_we
);

    // a waiting result holds its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // one item at a time: no input beat right after another
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in flight");

    // a new modulus needs its reciprocal before any index is taken
    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !s_tready)
        else $error("input ready right after a modulus write");

    // even the quickest item passes through the finish state before reaching the output
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after its input beat");

    // the reciprocal rebuild after a write takes no beat, checked at one point in it
    a_cfg_two: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> ##2 !(s_tvalid && s_tready))
        else $error("input beat accepted during reciprocal rebuild");

endmodule

bind fibonacci_mod_matrix_power fmmp_checker u_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import fmmp_pkg::*;

    localparam int WATCH_LIMIT = 60000;
    localparam int HOLD_CYCLES = 12000;
    localparam int HOLD_AT     = 150;

    typedef bit [3:0][63:0] mat_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IDX_W-1:0] s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [MOD_W-1:0] m_tdata;
    logic             cfg_we = 1'b0;
    logic [MOD_W-1:0] cfg_wdata = '0;

    bit [IDX_W-1:0] index_q[$];
    bit [MOD_W-1:0] fib_q[$];
    bit [MOD_W-1:0] modulus_now = MOD_RESET;
    int             send_idle = 0;
    int             rx_stall = 0;
    int             rx_count = 0;
    int             hold_left = 0;
    bit             hold_done = 1'b0;
    int             quiet_cycles = 0;
    int             err_cnt = 0;

    fibonacci_mod_matrix_power #(.INDEX_BITS(IDX_W)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic mat_t mat_mul(mat_t x, mat_t y, bit [63:0] mm);
        mat_t z;
        z[0] = ((x[0] * y[0]) % mm + (x[1] * y[2]) % mm) % mm;
        z[1] = ((x[0] * y[1]) % mm + (x[1] * y[3]) % mm) % mm;
        z[2] = ((x[2] * y[0]) % mm + (x[3] * y[2]) % mm) % mm;
        z[3] = ((x[2] * y[1]) % mm + (x[3] * y[3]) % mm) % mm;
        return z;
    endfunction

    // F(n) mod m: powers of [[0,1],[1,1]] folded in lsb first
    function automatic bit [MOD_W-1:0] fib_mod(bit [IDX_W-1:0] n, bit [MOD_W-1:0] m);
        mat_t           pw;
        mat_t           acc;
        bit [63:0]      mm;
        bit [IDX_W-1:0] rest;
        pw   = {64'd1, 64'd1, 64'd1, 64'd0};
        acc  = {64'd1, 64'd0, 64'd0, 64'd1};
        mm   = 64'(m);
        rest = n;
        if (mm == 0)
            return '0;
        for (int i = 0; i < IDX_W && rest != 0; i++)
        begin
            if (rest[0])
                acc = mat_mul(acc, pw, mm);
            rest = rest >> 1;
            pw   = mat_mul(pw, pw, mm);
        end
        return acc[1][MOD_W-1:0];
    endfunction

    // mostly short indices, some mid-sized, a few long ones of up to 64 bits
    function automatic bit [IDX_W-1:0] random_index();
        bit [IDX_W-1:0] v;
        int             w;
        int             pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            w = $urandom_range(0, 16);
        else if (pick < 88)
            w = $urandom_range(17, 40);
        else
            w = $urandom_range(41, IDX_W);
        v = {$urandom, $urandom};
        if (w == 0)
            return '0;
        if (w < IDX_W)
            v = v & ((64'd1 << w) - 1);
        v[w-1] = 1'b1;
        return v;
    endfunction

    // sender: beats come from index_q, expectations are computed on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                fib_q.push_back(fib_mod(s_tdata, modulus_now));
            if (!s_tvalid || s_tready)
            begin
                if (index_q.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= index_q.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready, with one long hold-off to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && rx_count >= HOLD_AT)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rx_stall);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            rx_count <= rx_count + 1;
            if (fib_q.size() == 0)
            begin
                $error("fib_value: no result expected, got %0d", m_tdata);
                err_cnt++;
            end
            else if (m_tdata !== fib_q[0])
            begin
                $error("fib_value: expected %0d, got %0d", fib_q[0], m_tdata);
                err_cnt++;
                void'(fib_q.pop_front());
            end
            else
                void'(fib_q.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic settle();
        while (index_q.size() != 0 || fib_q.size() != 0 || s_tvalid)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic load_modulus(input bit [MOD_W-1:0] m);
        @(posedge clk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= m;
        modulus_now = m;
        @(posedge clk);
        cfg_we      <= 1'b0;
        @(negedge clk);
    endtask

    task automatic start_phase(input bit do_write, input bit [MOD_W-1:0] m,
                               input int idle_pct, input int stall_pct);
        settle();
        if (do_write)
            load_modulus(m);
        send_idle = idle_pct;
        rx_stall  = stall_pct;
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
            index_q.push_back(random_index());
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset modulus, full rate, directed indices first
        start_phase(1'b0, MOD_RESET, 0, 0);
        index_q.push_back(64'd0);
        index_q.push_back(64'd1);
        index_q.push_back(64'd2);
        index_q.push_back(64'd3);
        index_q.push_back(64'd10);
        index_q.push_back(64'd47);
        index_q.push_back(64'd48);
        index_q.push_back(64'd93);
        index_q.push_back(64'd94);
        index_q.push_back(64'h0000_0001_0000_0000);
        index_q.push_back(64'h8000_0000_0000_0000);
        index_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        index_q.push_back(64'h5555_5555_5555_5555);
        index_q.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        queue_random(40);

        // largest modulus, sender mostly idle
        start_phase(1'b1, 32'hFFFF_FFFF, 79, 0);
        index_q.push_back(64'd47);
        index_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        queue_random(60);

        // modulus one gives zero everywhere
        start_phase(1'b1, 32'd1, 0, 79);
        index_q.push_back(64'd0);
        index_q.push_back(64'd1);
        index_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        queue_random(10);

        // random modulus, receiver stalling; the long hold-off lands here
        start_phase(1'b1, $urandom_range(32'hFFFF_FFFE, 2), 0, 79);
        queue_random(60);

        start_phase(1'b1, 32'd2, 37, 37);
        queue_random(30);

        start_phase(1'b1, $urandom_range(1000, 3), 37, 37);
        queue_random(40);

        start_phase(1'b1, $urandom | 32'h8000_0000, 0, 0);
        queue_random(50);

        settle();
        repeat (50) @(negedge clk);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
